// ----- hw/rtl/spq_pkg.sv -----
// Shared constants and types for the sorted priority queue.
package spq_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned TAG_BITS = 16;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [TAG_BITS-1:0]        tag_t;
  typedef logic [CNT_BITS-1:0]        cnt_t;
  typedef logic [1:0]                 status_t;

  localparam logic    KIND_INSERT = 1'b0;
  localparam logic    KIND_REMOVE = 1'b1;

  localparam status_t STATUS_DONE  = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue built from a chain of cells.
// done_o is registered and is high in the cycle that follows the accepting edge.
// Throughput: one transaction per cycle; all cells compare and shift in parallel.
// busy_o stays low, so start_i may be held high every cycle.
// Reset empties the queue and clears the strobe; cell contents are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_priority_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 kind_i,
  input  spq_pkg::key_t        key_i,
  input  spq_pkg::tag_t        tag_i,
  output logic                 done_o,
  output spq_pkg::status_t     status_o,
  output spq_pkg::key_t        removed_key_o,
  output spq_pkg::tag_t        removed_tag_o,
  output spq_pkg::cnt_t        count_o
);

  localparam int unsigned N = spq_pkg::DEPTH;

  spq_pkg::cnt_t      count_q, count_d;
  logic               done_q;
  spq_pkg::status_t   status_q, status_d;
  spq_pkg::key_t      rkey_q, rkey_d;
  spq_pkg::tag_t      rtag_q, rtag_d;
  spq_pkg::cell_ctrl_t ctrl;

  logic               accept;
  logic               full, empty;
  logic [N-1:0]       stay;
  spq_pkg::key_t      cell_key [N];
  spq_pkg::tag_t      cell_tag [N];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == spq_pkg::cnt_t'(N));
  assign empty  = (count_q == '0);

  assign ctrl.ins = accept && (kind_i == spq_pkg::KIND_INSERT) && !full;
  assign ctrl.rem = accept && (kind_i == spq_pkg::KIND_REMOVE) && !empty;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic          occ;
    logic          lstay;
    spq_pkg::key_t lkey, rkey;
    spq_pkg::tag_t ltag, rtag;

    assign occ = (count_q > spq_pkg::cnt_t'(i));

    if (i == 0) begin : g_first
      assign lstay = 1'b1;
      assign lkey  = key_i;
      assign ltag  = tag_i;
    end else begin : g_mid
      assign lstay = stay[i-1];
      assign lkey  = cell_key[i-1];
      assign ltag  = cell_tag[i-1];
    end

    if (i == N - 1) begin : g_last
      assign rkey = cell_key[i];
      assign rtag = cell_tag[i];
    end else begin : g_body
      assign rkey = cell_key[i+1];
      assign rtag = cell_tag[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occ),
      .new_key_i   (key_i),
      .new_tag_i   (tag_i),
      .left_stay_i (lstay),
      .left_key_i  (lkey),
      .left_tag_i  (ltag),
      .right_key_i (rkey),
      .right_tag_i (rtag),
      .stay_o      (stay[i]),
      .key_o       (cell_key[i]),
      .tag_o       (cell_tag[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = spq_pkg::STATUS_DONE;
    rkey_d   = '0;
    rtag_d   = '0;
    if (kind_i == spq_pkg::KIND_INSERT) begin
      if (full) begin
        status_d = spq_pkg::STATUS_FULL;
      end else if (accept) begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = spq_pkg::STATUS_EMPTY;
      end else begin
        rkey_d = cell_key[0];
        rtag_d = cell_tag[0];
        if (accept) begin
          count_d = count_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rkey_q   <= rkey_d;
      rtag_q   <= rtag_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign removed_key_o = rkey_q;
  assign removed_tag_o = rtag_q;
  assign count_o       = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= spq_pkg::cnt_t'(N))
    else $error("entry count above depth");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_q)
    else $error("transaction without result strobe");

  a_full_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == spq_pkg::KIND_INSERT && full) |=>
      (status_q == spq_pkg::STATUS_FULL && count_q == spq_pkg::cnt_t'(N)))
    else $error("insert into full queue changed the count");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == spq_pkg::KIND_REMOVE && empty) |=>
      (status_q == spq_pkg::STATUS_EMPTY && count_q == '0 && rkey_q == '0))
    else $error("remove from empty queue misreported");

endmodule

// ----- hw/rtl/spq_cell.sv -----
// One storage cell of the sorted chain: keeps, takes the new entry, or shifts.
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occupied_i,
  input  spq_pkg::key_t       new_key_i,
  input  spq_pkg::tag_t       new_tag_i,
  input  logic                left_stay_i,
  input  spq_pkg::key_t       left_key_i,
  input  spq_pkg::tag_t       left_tag_i,
  input  spq_pkg::key_t       right_key_i,
  input  spq_pkg::tag_t       right_tag_i,
  output logic                stay_o,
  output spq_pkg::key_t       key_o,
  output spq_pkg::tag_t       tag_o
);

  spq_pkg::key_t key_q, key_d;
  spq_pkg::tag_t tag_q, tag_d;

  assign stay_o = occupied_i && (key_q <= new_key_i);

  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    if (ctrl_i.ins && !stay_o) begin
      if (left_stay_i) begin
        key_d = new_key_i;
        tag_d = new_tag_i;
      end else begin
        key_d = left_key_i;
        tag_d = left_tag_i;
      end
    end else if (ctrl_i.rem) begin
      key_d = right_key_i;
      tag_d = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule
